// ----- rtl/gl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gl_pkg: shared definitions for the gradient level table
// Field widths, register and command codes, controller/datapath structs and
// the divide-by-255 helper used in the output scaling.
// ----------------------------------------------------------------------------
package gl_pkg;

    localparam int DEF_MAX_POINTS = 32;
    localparam int DEF_MAX_TABLE  = 4096;

    localparam int W_CMD      = 1;
    localparam int W_SLOT     = 5;
    localparam int W_POS      = 11;
    localparam int W_LVL      = 8;
    localparam int W_IDX      = 12;
    localparam int W_SIZE     = 13;
    localparam int W_SCALE    = 8;
    localparam int W_CFG_IDX  = 2;
    localparam int W_CFG_DATA = 13;

    // positions are fixed point with ten fraction bits of the table range
    localparam int POS_FRAC  = 10;
    localparam int POS_STEPS = POS_FRAC + 1;
    localparam int LVL_STEPS = W_LVL;
    localparam int W_DV      = W_SIZE;
    localparam int W_DVQ     = POS_STEPS;
    localparam int W_NUM     = W_LVL + W_POS;
    localparam int W_PROD    = W_LVL + W_SCALE;
    localparam int W_CNT     = 4;

    localparam logic [W_CMD-1:0] CMD_WRITE = 1'b0;
    localparam logic [W_CMD-1:0] CMD_QUERY = 1'b1;

    localparam logic [W_CFG_IDX-1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_SCALE      = 2'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_REVERSE    = 2'd2;

    localparam logic [W_SIZE-1:0]  RST_TABLE_SIZE = 13'd256;
    localparam logic [W_SCALE-1:0] RST_SCALE      = 8'd255;
    localparam logic               RST_REVERSE    = 1'b0;

    typedef struct packed {
        logic accept_write;
        logic accept_query;
        logic div_step;
        logic srch_start;
        logic srch_step;
        logic fetch_lo;
        logic fetch_hi;
        logic fetch_end;
        logic calc;
        logic adj;
        logic scale_mul;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic size_small;
        logic srch_more;
        logic srch_last;
        logic direct;
        logic out_free;
    } t_dp_stat;

    // exact floor(x / 255) for x up to 255 * 255
    function automatic logic [W_LVL-1:0] div255(input logic [W_PROD-1:0] x);
        logic [W_PROD:0] t;
        t = {1'b0, x} + {{(W_LVL+1){1'b0}}, x[W_PROD-1:W_LVL]} + 1'b1;
        return t[W_PROD-1:W_LVL];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/gl_item_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gl_item_if: input item channel
// Valid/ready channel carrying one control point write or one table query.
// ----------------------------------------------------------------------------
interface gl_item_if;
    import gl_pkg::*;

    logic              valid;
    logic              ready;
    logic [W_CMD-1:0]  cmd;
    logic [W_SLOT-1:0] point_slot;
    logic [W_POS-1:0]  point_position;
    logic [W_LVL-1:0]  point_level;
    logic [W_IDX-1:0]  entry_index;

    modport source (
        output valid, cmd, point_slot, point_position, point_level, entry_index,
        input  ready
    );
    modport sink (
        input  valid, cmd, point_slot, point_position, point_level, entry_index,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/gl_result_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gl_result_if: result channel
// Valid/ready channel carrying one scaled level per query.
// ----------------------------------------------------------------------------
interface gl_result_if;
    import gl_pkg::*;

    logic             valid;
    logic             ready;
    logic [W_LVL-1:0] level;
    logic             out_of_range;

    modport source (output valid, level, out_of_range, input ready);
    modport sink   (input valid, level, out_of_range, output ready);
endinterface
`default_nettype wire

// ----- rtl/gl_cfg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gl_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface gl_cfg_if;
    import gl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [W_CFG_IDX-1:0]  index;
    logic [W_CFG_DATA-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/gl_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gl_ctrl: query sequencer
// Steps the datapath through position divide, segment search, point fetch,
// interpolation divide and scaling, one query at a time.
// ----------------------------------------------------------------------------
module gl_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  logic [gl_pkg::W_CMD-1:0]      i_item_cmd,
    input  gl_pkg::t_dp_stat              i_stat,
    output logic                          o_item_ready,
    output gl_pkg::t_dp_cmd               o_cmd
);
    import gl_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_SRCH0 = 4'd2;
    localparam logic [3:0] S_SRCH  = 4'd3;
    localparam logic [3:0] S_F0    = 4'd4;
    localparam logic [3:0] S_F1    = 4'd5;
    localparam logic [3:0] S_F2    = 4'd6;
    localparam logic [3:0] S_CALC  = 4'd7;
    localparam logic [3:0] S_IDIV  = 4'd8;
    localparam logic [3:0] S_ADJ   = 4'd9;
    localparam logic [3:0] S_SCALE = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]       r_state, n_state;
    logic [W_CNT-1:0] r_cnt, n_cnt;

    assign o_item_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    if (i_item_cmd == CMD_QUERY) begin
                        o_cmd.accept_query = 1'b1;
                        n_cnt   = W_CNT'(POS_STEPS - 1);
                        n_state = i_stat.size_small ? S_SRCH0 : S_DIV;
                    end else begin
                        o_cmd.accept_write = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_SRCH0;
                end
            end
            S_SRCH0: begin
                o_cmd.srch_start = 1'b1;
                n_state = S_SRCH;
            end
            S_SRCH: begin
                o_cmd.srch_step = 1'b1;
                if (!i_stat.srch_more || i_stat.srch_last) begin
                    n_state = S_F0;
                end
            end
            S_F0: begin
                o_cmd.fetch_lo = 1'b1;
                n_state = S_F1;
            end
            S_F1: begin
                o_cmd.fetch_hi = 1'b1;
                n_state = S_F2;
            end
            S_F2: begin
                o_cmd.fetch_end = 1'b1;
                n_state = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_cnt   = W_CNT'(LVL_STEPS - 1);
                n_state = i_stat.direct ? S_SCALE : S_IDIV;
            end
            S_IDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_ADJ;
                end
            end
            S_ADJ: begin
                o_cmd.adj = 1'b1;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale_mul = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register can take the beat
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/gl_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gl_dp: gradient table datapath
// Configuration registers, control point memory, shared restoring divider,
// segment search pointer, interpolation and scaling, output register.
// ----------------------------------------------------------------------------
module gl_dp #(
    parameter int MAX_POINTS = gl_pkg::DEF_MAX_POINTS,
    parameter int MAX_TABLE  = gl_pkg::DEF_MAX_TABLE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gl_pkg::t_dp_cmd                i_cmd,
    output gl_pkg::t_dp_stat               o_stat,
    input  logic [gl_pkg::W_SLOT-1:0]      i_point_slot,
    input  logic [gl_pkg::W_POS-1:0]       i_point_position,
    input  logic [gl_pkg::W_LVL-1:0]       i_point_level,
    input  logic [gl_pkg::W_IDX-1:0]       i_entry_index,
    input  logic                           i_cfg_valid,
    input  logic [gl_pkg::W_CFG_IDX-1:0]   i_cfg_index,
    input  logic [gl_pkg::W_CFG_DATA-1:0]  i_cfg_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [gl_pkg::W_LVL-1:0]       o_level,
    output logic                           o_out_of_range
);
    import gl_pkg::*;

    localparam int PW = $clog2(MAX_POINTS);
    localparam logic [PW-1:0] K_LAST = PW'(MAX_POINTS - 2);

    // configuration
    logic [W_SIZE-1:0]  r_table_size;
    logic [W_SCALE-1:0] r_scale;
    logic               r_reverse;

    // control point memory
    logic [W_POS-1:0] r_pos_mem [MAX_POINTS];
    logic [W_LVL-1:0] r_lvl_mem [MAX_POINTS];
    logic [W_POS-1:0] r_pos_rd;
    logic [W_LVL-1:0] r_lvl_rd;
    logic [PW-1:0]    rd_addr;
    logic [PW-1:0]    wr_addr;
    logic             slot_ok;

    // shared divider
    logic [W_DV-1:0]  r_dv_rem;
    logic [W_DV-1:0]  r_dv_div;
    logic [W_DVQ-1:0] r_dv_bits;
    logic [W_DVQ-1:0] r_dv_quo;
    logic [W_DV:0]    dv_try;
    logic [W_DV:0]    dv_sub;
    logic             dv_ge;

    // query state
    logic [PW-1:0]     r_k;
    logic              r_beyond;
    logic              r_oor;
    logic [W_POS-1:0]  r_pos;
    logic [W_POS-1:0]  r_p0;
    logic [W_POS-1:0]  r_p1;
    logic [W_LVL-1:0]  r_l0;
    logic [W_LVL-1:0]  r_l1;
    logic [W_LVL-1:0]  r_c;
    logic              r_neg;
    logic [W_PROD-1:0] r_prod;

    // output register
    logic              r_out_valid;
    logic [W_LVL-1:0]  r_level;
    logic              r_out_oor;

    logic [W_SIZE-1:0] size;
    logic [W_SIZE-1:0] size_m1;
    logic [W_SIZE-1:0] idx_in;
    logic              idx_oor;
    logic [W_SIZE-1:0] idx_clamp;
    logic [W_SIZE-1:0] idx_eff;

    logic              below;
    logic              lvl_neg;
    logic [W_LVL-1:0]  lvl_mag;
    logic [W_POS-1:0]  pos_off;
    logic [W_POS-1:0]  span;
    logic [W_NUM-1:0]  num;

    // ---- query setup: clamp, mirror, position divider operands ----
    assign size = (32'(r_table_size) > 32'(MAX_TABLE)) ? W_SIZE'(MAX_TABLE) : r_table_size;
    assign size_m1   = size - 1'b1;
    assign idx_in    = {1'b0, i_entry_index};
    assign idx_oor   = (idx_in >= size);
    assign idx_clamp = idx_oor ? ((size == '0) ? '0 : size_m1) : idx_in;
    assign idx_eff   = r_reverse ? (size_m1 - idx_clamp) : idx_clamp;

    // ---- divider step: shift in one dividend bit, subtract if it fits ----
    assign dv_try = {r_dv_rem, r_dv_bits[W_DVQ-1]};
    assign dv_sub = dv_try - {1'b0, r_dv_div};
    assign dv_ge  = (dv_try >= {1'b0, r_dv_div});

    // ---- interpolation operands ----
    assign below   = (r_pos < r_p0);
    assign lvl_neg = (r_l1 < r_l0);
    assign lvl_mag = lvl_neg ? (r_l0 - r_l1) : (r_l1 - r_l0);
    assign pos_off = r_pos - r_p0;
    assign span    = r_p1 - r_p0;
    assign num     = W_NUM'(lvl_mag) * W_NUM'(pos_off);

    // ---- memory ----
    assign slot_ok = (32'(i_point_slot) < 32'(MAX_POINTS));
    assign wr_addr = PW'(i_point_slot);

    always_comb begin
        if (i_cmd.srch_start) begin
            rd_addr = PW'(1);
        end else if (i_cmd.fetch_lo) begin
            rd_addr = r_k;
        end else if (i_cmd.fetch_hi) begin
            rd_addr = r_k + PW'(1);
        end else begin
            // search runs one point ahead of the compare
            rd_addr = r_k + PW'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_write && slot_ok) begin
            r_pos_mem[wr_addr] <= i_point_position;
            r_lvl_mem[wr_addr] <= i_point_level;
        end
        r_pos_rd <= r_pos_mem[rd_addr];
        r_lvl_rd <= r_lvl_mem[rd_addr];
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= RST_TABLE_SIZE;
            r_scale      <= RST_SCALE;
            r_reverse    <= RST_REVERSE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TABLE_SIZE: r_table_size <= i_cfg_data[W_SIZE-1:0];
                    CFG_SCALE:      r_scale      <= i_cfg_data[W_SCALE-1:0];
                    CFG_REVERSE:    r_reverse    <= i_cfg_data[0];
                    default:        ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_query) begin
            r_oor     <= idx_oor;
            r_dv_rem  <= {1'b0, idx_eff[W_SIZE-1:1]};
            r_dv_div  <= size_m1;
            r_dv_bits <= {idx_eff[0], {POS_FRAC{1'b0}}};
            r_dv_quo  <= '0;
        end
        if (i_cmd.div_step) begin
            r_dv_rem  <= dv_ge ? dv_sub[W_DV-1:0] : dv_try[W_DV-1:0];
            r_dv_bits <= {r_dv_bits[W_DVQ-2:0], 1'b0};
            r_dv_quo  <= {r_dv_quo[W_DVQ-2:0], dv_ge};
        end
        if (i_cmd.srch_start) begin
            r_k      <= '0;
            r_beyond <= 1'b0;
            r_pos    <= r_dv_quo;
        end
        if (i_cmd.srch_step && o_stat.srch_more) begin
            r_k <= r_k + 1'b1;
            if (o_stat.srch_last) begin
                r_beyond <= 1'b1;
            end
        end
        if (i_cmd.fetch_hi) begin
            r_p0 <= r_pos_rd;
            r_l0 <= r_lvl_rd;
        end
        if (i_cmd.fetch_end) begin
            r_p1 <= r_pos_rd;
            r_l1 <= r_lvl_rd;
        end
        if (i_cmd.calc) begin
            r_oor     <= r_oor | r_beyond | below;
            r_c       <= r_l0;
            r_neg     <= lvl_neg;
            r_dv_rem  <= W_DV'(num[W_NUM-1:LVL_STEPS]);
            r_dv_div  <= W_DV'(span);
            r_dv_bits <= {num[LVL_STEPS-1:0], {(W_DVQ-LVL_STEPS){1'b0}}};
            r_dv_quo  <= '0;
        end
        if (i_cmd.adj) begin
            r_c <= r_neg ? (r_c - r_dv_quo[W_LVL-1:0]) : (r_c + r_dv_quo[W_LVL-1:0]);
        end
        if (i_cmd.scale_mul) begin
            r_prod <= W_PROD'(r_c) * W_PROD'(r_scale);
        end
        if (i_cmd.out_load) begin
            r_level   <= div255(r_prod);
            r_out_oor <= r_oor;
        end
    end

    assign o_stat.size_small = (size < W_SIZE'(2));
    assign o_stat.srch_more  = (r_pos > r_pos_rd);
    assign o_stat.srch_last  = (r_k == K_LAST);
    assign o_stat.direct     = r_beyond | below | (r_p1 == r_p0);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_level        = r_level;
    assign o_out_of_range = r_out_oor;

endmodule
`default_nettype wire

// ----- rtl/gradient_level_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_level_table: piecewise linear level table
// Stores gradient control points and answers table queries with the
// interpolated, scaled level.
//
//   channel    dir   handshake        beat contents
//   i_item     in    valid/ready      cmd, point_slot, point_position,
//                                     point_level, entry_index
//   o_result   out   valid/ready      level, out_of_range
//   i_cfg      in    valid/ready      index, data (ready always high)
//
// A point write is taken in idle and leaves the input ready. A query runs, up
// to the result register, through the position divide, serial search reads on
// the point memory port for the segment k (k < MAX_POINTS), 3 fetches, the
// interpolation divide, and setup and scaling; no new item is taken until the
// result is loaded. A segment needing no divide skips the interpolation
// divide; a table size below two skips the position divide. Synchronous
// active-low reset idles the sequencer, loads the configuration defaults and
// drops result valid; the point memory and query registers are not cleared.
// A stalled result holds in its register and the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module gradient_level_table #(
    parameter int MAX_POINTS = gl_pkg::DEF_MAX_POINTS,
    parameter int MAX_TABLE  = gl_pkg::DEF_MAX_TABLE
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gl_item_if.sink       i_item,
    gl_result_if.source   o_result,
    gl_cfg_if.sink        i_cfg
);
    import gl_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     item_ready;

    assign i_item.ready = item_ready;
    assign i_cfg.ready  = 1'b1;

    gl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .i_item_cmd   (i_item.cmd),
        .i_stat       (dp_stat),
        .o_item_ready (item_ready),
        .o_cmd        (dp_cmd)
    );

    gl_dp #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_TABLE  (MAX_TABLE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_point_slot     (i_item.point_slot),
        .i_point_position (i_item.point_position),
        .i_point_level    (i_item.point_level),
        .i_entry_index    (i_item.entry_index),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_level          (o_result.level),
        .o_out_of_range   (o_result.out_of_range)
    );

`ifndef NO_ASSERTIONS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(dp_cmd))
        else $error("more than one datapath command at once");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready && i_item.cmd == CMD_QUERY) |=> !i_item.ready)
        else $error("input taken while a query is in flight");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready && i_item.cmd == CMD_WRITE) |=> i_item.ready)
        else $error("point write left the sequencer busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> (!o_result.valid || o_result.ready))
        else $error("result register overwritten before its beat was taken");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(dp_cmd.out_load))
        else $error("result valid rose without a result load");
`endif

endmodule
`default_nettype wire
